[hdl/lks_pkg.sv]
// Shared types, constants and command codes for the LED/key serial master.
// Used by every module of the block; depends on nothing.
package lks_pkg;

   localparam int DISPLAY_BYTES_DEF = 16;
   localparam int KEY_BYTES_DEF     = 4;

   localparam logic [7:0] FRAME_DATA_MODE  = 8'h40;
   localparam logic [7:0] FRAME_ADDR_START = 8'hC0;
   localparam logic [7:0] FRAME_READ_KEYS  = 8'h42;
   localparam logic [7:0] CONTROL_RESET    = 8'h8F;
   localparam logic [7:0] PHASE_RESET      = 8'h01;

   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_LOAD    = 3'd1;
   localparam logic [2:0] CMD_CONTROL = 3'd2;
   localparam logic [2:0] CMD_CLEAR   = 3'd3;
   localparam logic [2:0] CMD_REFRESH = 3'd4;
   localparam logic [2:0] CMD_KEYS    = 3'd5;

   localparam logic CSR_DISPLAY_CONTROL = 1'b0;
   localparam logic CSR_PHASE_TICKS     = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_PRE   = 8'b0000_0010,
      ST_WLOW  = 8'b0000_0100,
      ST_WHIGH = 8'b0000_1000,
      ST_POST  = 8'b0001_0000,
      ST_GAP   = 8'b0010_0000,
      ST_RLOW  = 8'b0100_0000,
      ST_RHIGH = 8'b1000_0000
   } lks_state_type;

   typedef struct packed {
      logic       clk_pin;
      logic       stb_pin;
      logic       dio_out;
      logic       dio_drive;
      logic       busy_res;
      logic       key_valid;
      logic [7:0] key_byte;
      logic       key_last;
      logic       rejected;
   } lks_result_type;

endpackage

[hdl/led_key_serial_master.sv]
// Top level of the LED/key serial master: stream ports, configuration registers
// and result register. Instantiates lks_store and lks_seq; uses lks_pkg.
//
// Each input item is one tick of the pin sequencer and yields exactly one result
// item, so the block takes one item per clock cycle, every cycle, and pauses only
// while the result register holds an item the sink has not taken. The display
// store is a 16 x 8 synchronous memory with a registered read at the current byte
// position, so a refresh byte is ready before its frame starts; per-entry valid
// bits give the all-zero store right after reset, with no clearing pass.
module led_key_serial_master #(
   parameter int DISPLAY_BYTES = lks_pkg::DISPLAY_BYTES_DEF,
   parameter int KEY_BYTES     = lks_pkg::KEY_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // byte_index[3:0], data_byte[11:4], dio_in[12], zero
   input  logic [2:0]  req_tuser,  // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // clk_pin, stb_pin, dio_out, dio_drive, busy_res,
                                   // key_byte[12:5], rejected[13], zero
   output logic        rsp_tuser,  // key_valid
   output logic        rsp_tlast,  // key_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   localparam int AW = (DISPLAY_BYTES > 1) ? $clog2(DISPLAY_BYTES) : 1;

   logic                    fire;
   logic [7:0]              ctrl_ff;
   logic [7:0]              phase_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   lks_pkg::lks_result_type res_ff;
   lks_pkg::lks_result_type res;
   logic [AW-1:0]           rd_addr;
   logic [7:0]              rd_data;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [7:0]              wr_data;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign fire         = req_tvalid && req_tready;
   assign csr_ready    = 1'b1;
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   lks_store #(
      .DEPTH (DISPLAY_BYTES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en && fire),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lks_seq #(
      .DISPLAY_BYTES (DISPLAY_BYTES),
      .KEY_BYTES     (KEY_BYTES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .cmd        (req_tuser),
      .idx        (req_tdata[3:0]),
      .data       (req_tdata[11:4]),
      .dio        (req_tdata[12]),
      .ctrl       (ctrl_ff),
      .phase      (phase_ff),
      .store_byte (rd_data),
      .rd_addr    (rd_addr),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff  <= lks_pkg::CONTROL_RESET;
         phase_ff <= lks_pkg::PHASE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            lks_pkg::CSR_DISPLAY_CONTROL: ctrl_ff  <= csr_data;
            lks_pkg::CSR_PHASE_TICKS:     phase_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, res_ff.rejected, res_ff.key_byte, res_ff.busy_res,
                        res_ff.dio_drive, res_ff.dio_out, res_ff.stb_pin, res_ff.clk_pin};
   assign rsp_tuser  = res_ff.key_valid;
   assign rsp_tlast  = res_ff.key_last;

endmodule

[hdl/lks_store.sv]
// Display store: synchronous memory, one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses lks_pkg.
module lks_store #(
   parameter int DEPTH = lks_pkg::DISPLAY_BYTES_DEF,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0]       mem_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [7:0]       rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : 8'h00;

endmodule

[hdl/lks_seq.sv]
// Pin sequencer: advances the frame, bit and phase counters by one tick per item
// and builds the pin levels and key results. Uses lks_pkg; reads lks_store.
module lks_seq #(
   parameter int DISPLAY_BYTES = lks_pkg::DISPLAY_BYTES_DEF,
   parameter int KEY_BYTES     = lks_pkg::KEY_BYTES_DEF,
   localparam int AW = (DISPLAY_BYTES > 1) ? $clog2(DISPLAY_BYTES) : 1,
   localparam int CMAX = (DISPLAY_BYTES + 1 > KEY_BYTES) ? DISPLAY_BYTES + 1 : KEY_BYTES,
   localparam int CW = $clog2(CMAX + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [2:0]             cmd,
   input  logic [3:0]             idx,
   input  logic [7:0]             data,
   input  logic                   dio,
   input  logic [7:0]             ctrl,
   input  logic [7:0]             phase,
   input  logic [7:0]             store_byte,
   output logic [AW-1:0]          rd_addr,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output logic [7:0]             wr_data,
   output lks_pkg::lks_result_type res
);

   lks_pkg::lks_state_type state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic          frame_ff, frame_in;
   logic [7:0]    shift_ff, shift_in;
   logic [2:0]    bit_ff, bit_in;
   logic [CW-1:0] byte_ff, byte_in;
   logic [7:0]    tick_ff, tick_in;
   logic          clk_ff, clk_in;
   logic          stb_ff, stb_in;
   logic          dio_ff, dio_in;
   logic          drive_ff, drive_in;

   function automatic logic [7:0] frame_byte(logic [2:0] op, logic frame, logic first,
                                             logic [7:0] cbyte, logic [7:0] sbyte);
      logic [7:0] fb;
      if (op == lks_pkg::CMD_CONTROL) begin
         fb = cbyte;
      end else if (op == lks_pkg::CMD_KEYS) begin
         fb = lks_pkg::FRAME_READ_KEYS;
      end else if (!frame) begin
         fb = lks_pkg::FRAME_DATA_MODE;
      end else if (first) begin
         fb = lks_pkg::FRAME_ADDR_START;
      end else if (op == lks_pkg::CMD_REFRESH) begin
         fb = sbyte;
      end else begin
         fb = 8'h00;
      end
      return fb;
   endfunction

   assign rd_addr = (byte_ff < CW'(DISPLAY_BYTES)) ? AW'(byte_ff) : '0;

   always_comb begin
      logic [7:0]    period;
      logic [7:0]    tick_nx;
      logic [CW-1:0] byte_nx;
      logic          multi;
      logic [7:0]    key_sr;

      state_in = state_ff;
      op_in    = op_ff;
      frame_in = frame_ff;
      shift_in = shift_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      tick_in  = tick_ff;
      clk_in   = clk_ff;
      stb_in   = stb_ff;
      dio_in   = dio_ff;
      drive_in = drive_ff;
      wr_en    = 1'b0;
      wr_addr  = AW'(idx);
      wr_data  = data;
      res      = '0;

      period  = (phase == 8'h00) ? 8'h01 : phase;
      tick_nx = tick_ff + 8'h01;
      byte_nx = byte_ff + CW'(1);
      multi   = (op_ff == lks_pkg::CMD_CLEAR) || (op_ff == lks_pkg::CMD_REFRESH);
      key_sr  = {shift_ff[6:0], dio};

      if (state_ff == lks_pkg::ST_IDLE) begin
         if (cmd == lks_pkg::CMD_LOAD) begin
            wr_en = (6'(idx) < 6'(DISPLAY_BYTES));
         end else if (cmd >= lks_pkg::CMD_CONTROL && cmd <= lks_pkg::CMD_KEYS) begin
            op_in    = cmd;
            frame_in = 1'b0;
            byte_in  = '0;
            state_in = lks_pkg::ST_PRE;
            tick_in  = 8'h00;
            stb_in   = 1'b0;
            clk_in   = 1'b1;
            drive_in = 1'b1;
            shift_in = frame_byte(cmd, 1'b0, 1'b1, ctrl, store_byte);
            bit_in   = 3'd0;
         end
      end else begin
         res.rejected = (cmd >= lks_pkg::CMD_LOAD) && (cmd <= lks_pkg::CMD_KEYS);
         tick_in = tick_nx;
         if (tick_nx >= period) begin
            tick_in = 8'h00;
            case (state_ff)
               lks_pkg::ST_PRE: begin
                  state_in = lks_pkg::ST_WLOW;
                  clk_in   = 1'b0;
                  drive_in = 1'b1;
                  dio_in   = shift_ff[0];
               end
               lks_pkg::ST_WLOW: begin
                  state_in = lks_pkg::ST_WHIGH;
                  clk_in   = 1'b1;
               end
               lks_pkg::ST_WHIGH: begin
                  shift_in = {1'b0, shift_ff[7:1]};
                  clk_in   = 1'b1;
                  if (bit_ff == 3'd7) begin
                     state_in = lks_pkg::ST_POST;
                  end else begin
                     bit_in   = bit_ff + 3'd1;
                     state_in = lks_pkg::ST_WLOW;
                     clk_in   = 1'b0;
                     drive_in = 1'b1;
                     dio_in   = shift_ff[1];
                  end
               end
               lks_pkg::ST_POST: begin
                  byte_in = byte_nx;
                  if (multi && frame_ff && (byte_nx < CW'(DISPLAY_BYTES + 1))) begin
                     state_in = lks_pkg::ST_PRE;
                     stb_in   = 1'b0;
                     clk_in   = 1'b1;
                     drive_in = 1'b1;
                     shift_in = frame_byte(op_ff, frame_ff, 1'b0, ctrl, store_byte);
                     bit_in   = 3'd0;
                  end else if (op_ff == lks_pkg::CMD_KEYS) begin
                     byte_in  = '0;
                     bit_in   = 3'd0;
                     shift_in = 8'h00;
                     state_in = lks_pkg::ST_RLOW;
                     clk_in   = 1'b0;
                     drive_in = 1'b0;
                     dio_in   = 1'b1;
                  end else if (multi && !frame_ff) begin
                     state_in = lks_pkg::ST_GAP;
                     stb_in   = 1'b1;
                     clk_in   = 1'b1;
                  end else begin
                     state_in = lks_pkg::ST_IDLE;
                     clk_in   = 1'b1;
                     stb_in   = 1'b1;
                     dio_in   = 1'b1;
                     drive_in = 1'b1;
                     op_in    = lks_pkg::CMD_NONE;
                     frame_in = 1'b0;
                  end
               end
               lks_pkg::ST_GAP: begin
                  frame_in = 1'b1;
                  byte_in  = '0;
                  state_in = lks_pkg::ST_PRE;
                  stb_in   = 1'b0;
                  clk_in   = 1'b1;
                  drive_in = 1'b1;
                  shift_in = frame_byte(op_ff, 1'b1, 1'b1, ctrl, store_byte);
                  bit_in   = 3'd0;
               end
               lks_pkg::ST_RLOW: begin
                  shift_in = key_sr;
                  if (bit_ff == 3'd7) begin
                     res.key_valid = 1'b1;
                     res.key_byte  = key_sr;
                     res.key_last  = (byte_nx >= CW'(KEY_BYTES));
                  end
                  state_in = lks_pkg::ST_RHIGH;
                  clk_in   = 1'b1;
               end
               lks_pkg::ST_RHIGH: begin
                  if (bit_ff == 3'd7) begin
                     bit_in   = 3'd0;
                     shift_in = 8'h00;
                     byte_in  = byte_nx;
                     if (byte_nx >= CW'(KEY_BYTES)) begin
                        state_in = lks_pkg::ST_IDLE;
                        clk_in   = 1'b1;
                        stb_in   = 1'b1;
                        dio_in   = 1'b1;
                        drive_in = 1'b1;
                        op_in    = lks_pkg::CMD_NONE;
                        frame_in = 1'b0;
                     end else begin
                        state_in = lks_pkg::ST_RLOW;
                        clk_in   = 1'b0;
                        drive_in = 1'b0;
                        dio_in   = 1'b1;
                     end
                  end else begin
                     bit_in   = bit_ff + 3'd1;
                     state_in = lks_pkg::ST_RLOW;
                     clk_in   = 1'b0;
                     drive_in = 1'b0;
                     dio_in   = 1'b1;
                  end
               end
               default: begin
                  state_in = lks_pkg::ST_IDLE;
                  clk_in   = 1'b1;
                  stb_in   = 1'b1;
                  dio_in   = 1'b1;
                  drive_in = 1'b1;
                  op_in    = lks_pkg::CMD_NONE;
                  frame_in = 1'b0;
               end
            endcase
         end
      end

      res.clk_pin   = clk_in;
      res.stb_pin   = stb_in;
      res.dio_out   = drive_in ? dio_in : 1'b1;
      res.dio_drive = drive_in;
      res.busy_res  = (state_in != lks_pkg::ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lks_pkg::ST_IDLE;
         op_ff    <= lks_pkg::CMD_NONE;
         frame_ff <= 1'b0;
         shift_ff <= 8'h00;
         bit_ff   <= 3'd0;
         byte_ff  <= '0;
         tick_ff  <= 8'h00;
         clk_ff   <= 1'b1;
         stb_ff   <= 1'b1;
         dio_ff   <= 1'b1;
         drive_ff <= 1'b1;
      end else if (fire) begin
         state_ff <= state_in;
         op_ff    <= op_in;
         frame_ff <= frame_in;
         shift_ff <= shift_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         tick_ff  <= tick_in;
         clk_ff   <= clk_in;
         stb_ff   <= stb_in;
         dio_ff   <= dio_in;
         drive_ff <= drive_in;
      end
   end

endmodule

[hdl/lks_checker.sv]
// Port-level checks for led_key_serial_master, attached by the bind below.
// Depends only on the top level's ports.
module lks_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item present right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   a_last_key: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("last key flag without key byte");

   a_key_released: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[3] && rsp_tdata[0] && rsp_tdata[4])
      else $error("key byte reported while data line driven or clock low");

   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4] |-> rsp_tdata[3:0] == 4'b1111)
      else $error("pins not at idle levels while not busy");

endmodule

bind led_key_serial_master lks_checker u_lks_checker (.*);
